// ----- src/region_work_splitter_macros.svh -----
// Assertion macros shared by the region work splitter RTL.
// Needs signals named clock and reset in the including module.
`ifndef REGION_WORK_SPLITTER_MACROS_SVH
`define REGION_WORK_SPLITTER_MACROS_SVH

// Condition that must hold every cycle out of reset.
`define RWS_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Condition in one cycle that forces a result in the next.
`define RWS_ASSERT_NEXT(lbl, cond, nxt, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond) |=> (nxt)) \
      else $error(msg);

`endif

// ----- src/rws_pkg.sv -----
// Package for the region work splitter: widths, defaults and the
// divider command/status types. No dependencies.
package rws_pkg;

   localparam int COORD_W   = 16;  // region coordinates and extents
   localparam int POS_W     = 17;  // part start coordinate
   localparam int WORKER_W  = 7;   // worker count register
   localparam int PART_W    = 7;   // part count and part index
   localparam int DIVISOR_W = 7;   // holds a part count, at most 64
   localparam int CNT_W     = $clog2(COORD_W + 1);

   localparam int COLUMN_GRANULE_DEF = 16;
   localparam int MAX_WORKERS_DEF    = 64;

   localparam logic [WORKER_W-1:0] WORKER_RESET = WORKER_W'(1);

   typedef struct packed {
      logic                 start;
      logic [COORD_W-1:0]   dividend;
      logic [DIVISOR_W-1:0] divisor;
   } div_cmd_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

endpackage

// ----- src/rws_div.sv -----
// Restoring divider: one quotient bit per cycle while busy.
// Depends on rws_pkg and region_work_splitter_macros.svh.
`include "region_work_splitter_macros.svh"

module rws_div (
   input  logic                          clock,
   input  logic                          reset,
   input  rws_pkg::div_cmd_type          cmd,
   output rws_pkg::div_stat_type         stat,
   output logic [rws_pkg::COORD_W-1:0]   quotient,
   output logic [rws_pkg::DIVISOR_W-1:0] remainder
);

   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;
   logic [rws_pkg::CNT_W-1:0]     cnt_ff, cnt_in;
   logic [rws_pkg::COORD_W-1:0]   dvd_ff, dvd_in;    // dividend shifts out, quotient in
   logic [rws_pkg::DIVISOR_W-1:0] dsr_ff, dsr_in;
   logic [rws_pkg::DIVISOR_W-1:0] rem_ff, rem_in;
   logic [rws_pkg::DIVISOR_W:0]   trial;
   logic [rws_pkg::DIVISOR_W:0]   diff;
   logic                          fits;

   assign trial = {rem_ff, dvd_ff[rws_pkg::COORD_W-1]};
   assign diff  = trial - {1'b0, dsr_ff};
   assign fits  = trial >= {1'b0, dsr_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      dsr_in  = dsr_ff;
      rem_in  = rem_ff;
      if (cmd.start) begin
         busy_in = 1'b1;
         cnt_in  = rws_pkg::CNT_W'(rws_pkg::COORD_W);
         dvd_in  = cmd.dividend;
         dsr_in  = cmd.divisor;
         rem_in  = '0;
      end else if (busy_ff) begin
         rem_in = fits ? diff[rws_pkg::DIVISOR_W-1:0] : trial[rws_pkg::DIVISOR_W-1:0];
         dvd_in = {dvd_ff[rws_pkg::COORD_W-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == rws_pkg::CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      dsr_ff <= dsr_in;
      rem_ff <= rem_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign quotient  = dvd_ff;
   assign remainder = rem_ff;

   `RWS_ASSERT(a_no_restart, !(cmd.start && busy_ff), "divider started while busy")
   `RWS_ASSERT(a_busy_count, busy_ff == (cnt_ff != '0), "busy and count disagree")
   `RWS_ASSERT_NEXT(a_done_once, done_ff, !done_ff, "done held longer than one cycle")

endmodule

// ----- src/region_work_splitter.sv -----
// Region work splitter top level: sequencer, output register, config register.
// Depends on rws_pkg, rws_div and region_work_splitter_macros.svh.
//
// Usage:
//  - req channel (valid/ready) takes one region: x, y, width, height.
//  - rsp channel (valid/ready) returns one part per strip, low coordinate
//    first; last_part marks the final strip of the region.
//  - csr_wr_en/csr_wr_data write the worker count (0 acts as 1, values above
//    MAX_WORKERS act as MAX_WORKERS). Write only while the block is idle.
// Timing:
//  - req_ready is high only while idle; one region is in flight at a time.
//  - width / COLUMN_GRANULE is a reciprocal multiply; the single divider
//    then runs once per region on extent / parts.
//  - The first part is loaded into the output register after ST_COL_LIM,
//    ST_PICK and the divide in ST_DIV_EXT; after that one part per cycle
//    while rsp_ready is high.
// Stalls: a held part waits in the output register; the sequencer stops until
//  it is taken. The last part may still be waiting while a new request enters.
// Reset: synchronous, active high; worker count returns to 1, no part is
//  pending and the block comes up idle.
`include "region_work_splitter_macros.svh"

module region_work_splitter #(
   parameter int COLUMN_GRANULE = rws_pkg::COLUMN_GRANULE_DEF,
   parameter int MAX_WORKERS    = rws_pkg::MAX_WORKERS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,

   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [rws_pkg::COORD_W-1:0]   req_region_x,
   input  logic [rws_pkg::COORD_W-1:0]   req_region_y,
   input  logic [rws_pkg::COORD_W-1:0]   req_region_width,
   input  logic [rws_pkg::COORD_W-1:0]   req_region_height,

   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [rws_pkg::POS_W-1:0]     rsp_part_x,
   output logic [rws_pkg::POS_W-1:0]     rsp_part_y,
   output logic [rws_pkg::COORD_W-1:0]   rsp_part_width,
   output logic [rws_pkg::COORD_W-1:0]   rsp_part_height,
   output logic                          rsp_split_by_rows,
   output logic                          rsp_last_part,

   input  logic                          csr_wr_en,
   input  logic [rws_pkg::WORKER_W-1:0]  csr_wr_data
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_COL_LIM,   // width / granule by reciprocal multiply, clamp
      ST_PICK,      // choose axis and part count, start the divide
      ST_DIV_EXT,   // extent / parts in the divider
      ST_EMIT       // one strip per free output slot
   } state_type;

   // floor(w * RECIP >> 24) equals floor(w / granule) for 16-bit w, granule 1..256
   localparam int GRAN_SHIFT = 24;
   localparam int RECIP_W    = GRAN_SHIFT + 1;
   localparam int PROD_W     = GRAN_SHIFT + rws_pkg::COORD_W;
   localparam logic [RECIP_W-1:0] GRAN_RECIP =
      RECIP_W'(((longint'(1) << GRAN_SHIFT) + longint'(COLUMN_GRANULE) - 1)
               / longint'(COLUMN_GRANULE));
   localparam logic [rws_pkg::WORKER_W-1:0]  WMAX    = rws_pkg::WORKER_W'(MAX_WORKERS);

   state_type                     state_ff, state_in;
   logic [rws_pkg::WORKER_W-1:0]  worker_count_ff, worker_count_in;
   logic [rws_pkg::WORKER_W-1:0]  workers_ff, workers_in;   // clamped count, per region
   logic [rws_pkg::COORD_W-1:0]   rx_ff, rx_in, ry_ff, ry_in;
   logic [rws_pkg::COORD_W-1:0]   rw_ff, rw_in, rh_ff, rh_in;
   logic [rws_pkg::PART_W-1:0]    col_lim_ff, col_lim_in;
   logic [rws_pkg::PART_W-1:0]    parts_ff, parts_in;
   logic [rws_pkg::PART_W-1:0]    idx_ff, idx_in;
   logic [rws_pkg::PART_W-1:0]    extra_ff, extra_in;
   logic [rws_pkg::COORD_W-1:0]   base_ff, base_in;
   logic [rws_pkg::POS_W-1:0]     pos_ff, pos_in;
   logic                          rows_ff, rows_in;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic [rws_pkg::POS_W-1:0]     part_x_ff, part_x_in, part_y_ff, part_y_in;
   logic [rws_pkg::COORD_W-1:0]   part_w_ff, part_w_in, part_h_ff, part_h_in;
   logic                          split_rows_ff, split_rows_in;
   logic                          last_ff, last_in;

   rws_pkg::div_cmd_type          div_cmd;
   rws_pkg::div_stat_type         div_stat;
   logic [rws_pkg::COORD_W-1:0]   div_quot;
   logic [rws_pkg::DIVISOR_W-1:0] div_rem;

   logic [rws_pkg::WORKER_W-1:0]  workers_eff;
   logic [PROD_W-1:0]             gran_prod;   // 16 x 25 bit product
   logic [rws_pkg::COORD_W-1:0]   gran_quot;
   logic [rws_pkg::PART_W-1:0]    row_lim;
   logic                          pick_rows;
   logic [rws_pkg::COORD_W-1:0]   len;
   logic                          slot_free;
   logic                          is_last;

   rws_div u_div (
      .clock     (clock),
      .reset     (reset),
      .cmd       (div_cmd),
      .stat      (div_stat),
      .quotient  (div_quot),
      .remainder (div_rem)
   );

   // worker count as seen by a new region
   always_comb begin
      if (worker_count_ff == '0) begin
         workers_eff = rws_pkg::WORKER_W'(1);
      end else if (worker_count_ff > WMAX) begin
         workers_eff = WMAX;
      end else begin
         workers_eff = worker_count_ff;
      end
   end

   assign gran_prod = PROD_W'(rw_ff) * PROD_W'(GRAN_RECIP);
   assign gran_quot = gran_prod[PROD_W-1:GRAN_SHIFT];

   assign row_lim   = (rh_ff > rws_pkg::COORD_W'(workers_ff))
                      ? workers_ff : rh_ff[rws_pkg::PART_W-1:0];
   assign pick_rows = row_lim >= col_lim_ff;
   assign len       = base_ff + rws_pkg::COORD_W'(idx_ff < extra_ff);
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign is_last   = idx_ff == (parts_ff - 1'b1);

   always_comb begin
      state_in        = state_ff;
      worker_count_in = csr_wr_en ? csr_wr_data : worker_count_ff;
      workers_in      = workers_ff;
      rx_in           = rx_ff;
      ry_in           = ry_ff;
      rw_in           = rw_ff;
      rh_in           = rh_ff;
      col_lim_in      = col_lim_ff;
      parts_in        = parts_ff;
      idx_in          = idx_ff;
      extra_in        = extra_ff;
      base_in         = base_ff;
      pos_in          = pos_ff;
      rows_in         = rows_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_ready;
      part_x_in       = part_x_ff;
      part_y_in       = part_y_ff;
      part_w_in       = part_w_ff;
      part_h_in       = part_h_ff;
      split_rows_in   = split_rows_ff;
      last_in         = last_ff;
      div_cmd         = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               rx_in      = req_region_x;
               ry_in      = req_region_y;
               rw_in      = req_region_width;
               rh_in      = req_region_height;
               workers_in = workers_eff;
               state_in   = ST_COL_LIM;
            end
         end
         ST_COL_LIM: begin
            // floor at one, cap at the worker count
            if (gran_quot == '0) begin
               col_lim_in = rws_pkg::PART_W'(1);
            end else if (gran_quot > rws_pkg::COORD_W'(workers_ff)) begin
               col_lim_in = workers_ff;
            end else begin
               col_lim_in = gran_quot[rws_pkg::PART_W-1:0];
            end
            state_in = ST_PICK;
         end
         ST_PICK: begin
            rows_in          = pick_rows;
            parts_in         = pick_rows ? row_lim : col_lim_ff;
            pos_in           = pick_rows ? {1'b0, ry_ff} : {1'b0, rx_ff};
            div_cmd.start    = 1'b1;
            div_cmd.dividend = pick_rows ? rh_ff : rw_ff;
            div_cmd.divisor  = rws_pkg::DIVISOR_W'(pick_rows ? row_lim : col_lim_ff);
            state_in         = ST_DIV_EXT;
         end
         ST_DIV_EXT: begin
            if (div_stat.done) begin
               base_in  = div_quot;
               extra_in = div_rem[rws_pkg::PART_W-1:0];   // below the part count
               idx_in   = '0;
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (slot_free) begin
               rsp_valid_in  = 1'b1;
               part_x_in     = rows_ff ? {1'b0, rx_ff} : pos_ff;
               part_y_in     = rows_ff ? pos_ff : {1'b0, ry_ff};
               part_w_in     = rows_ff ? rw_ff : len;
               part_h_in     = rows_ff ? len : rh_ff;
               split_rows_in = rows_ff;
               last_in       = is_last;
               pos_in        = pos_ff + rws_pkg::POS_W'(len);
               idx_in        = idx_ff + 1'b1;
               if (is_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         worker_count_ff <= rws_pkg::WORKER_RESET;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         worker_count_ff <= worker_count_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
      workers_ff    <= workers_in;
      rx_ff         <= rx_in;
      ry_ff         <= ry_in;
      rw_ff         <= rw_in;
      rh_ff         <= rh_in;
      col_lim_ff    <= col_lim_in;
      parts_ff      <= parts_in;
      idx_ff        <= idx_in;
      extra_ff      <= extra_in;
      base_ff       <= base_in;
      pos_ff        <= pos_in;
      rows_ff       <= rows_in;
      part_x_ff     <= part_x_in;
      part_y_ff     <= part_y_in;
      part_w_ff     <= part_w_in;
      part_h_ff     <= part_h_in;
      split_rows_ff <= split_rows_in;
      last_ff       <= last_in;
   end

   assign req_ready         = state_ff == ST_IDLE;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_part_x        = part_x_ff;
   assign rsp_part_y        = part_y_ff;
   assign rsp_part_width    = part_w_ff;
   assign rsp_part_height   = part_h_ff;
   assign rsp_split_by_rows = split_rows_ff;
   assign rsp_last_part     = last_ff;

   `RWS_ASSERT(a_idx_in_range, (state_ff != ST_EMIT) || (idx_ff < parts_ff),
      "part index past part count")
   `RWS_ASSERT(a_extra_small, (state_ff != ST_EMIT) || (extra_ff < parts_ff),
      "remainder not below part count")
   `RWS_ASSERT(a_div_idle_emit, (state_ff != ST_EMIT) || !div_stat.busy,
      "divider busy while emitting")
   `RWS_ASSERT_NEXT(a_last_to_idle, (state_ff == ST_EMIT) && slot_free && is_last,
      (state_ff == ST_IDLE) && rsp_valid_ff && last_ff, "last part did not end the region")

endmodule
